@@ sv/sft_pkg.sv @@
// Shared types, widths and defaults for the sparse fast transpose block.
package sft_pkg;

  // Field widths
  localparam int ROW_W   = 8;
  localparam int COL_W   = 6;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 6;
  localparam int CFG_W   = 7;
  localparam int CMP_W   = 9;

  // Number of distinct column codes the column field can carry
  localparam int COL_SPAN = 2 ** COL_W;

  // Defaults
  localparam int DEF_MAX_ENTRIES = 32;
  localparam int DEF_MAX_COLUMNS = 64;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = 1;

  // One stored triplet
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  // One classified item on its way to the back end
  typedef struct packed {
    entry_t ent;
    logic   keep;
    logic   last;
  } item_t;

  // Back end sequencer
  typedef enum logic [3:0] {
    S_LOAD,
    S_LOAD_WR,
    S_PRE_RD,
    S_PRE_WR,
    S_SC_RD,
    S_SC_COL,
    S_SC_WR,
    S_EM_RD,
    S_EM_WR,
    S_DONE
  } back_state_t;

endpackage

@@ sv/sft_front.sv @@
// Front end: column count register and classification of incoming triplets.
module sft_front import sft_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    push,
  input  logic [ROW_W-1:0]        row_index,
  input  logic [COL_W-1:0]        column_index,
  input  logic signed [VAL_W-1:0] entry_value,
  input  logic                    is_last,
  input  logic                    q_full,
  output logic                    full,
  output logic                    q_push,
  output item_t                   q_item
);

  logic [CFG_W-1:0] column_count;
  logic             in_range;

  // Column count register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CFG_RESET;
    end else if (cfg_write) begin
      column_count <= cfg_data;
    end
  end

  // Keep only columns below both the configured count and the build limit
  assign in_range = (CMP_W'(column_index) < CMP_W'(column_count)) &&
                    (CMP_W'(column_index) < CMP_W'(MAX_COLUMNS));

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_item.ent.row = row_index;
    q_item.ent.col = column_index;
    q_item.ent.val = entry_value;
    q_item.keep    = in_range;
    q_item.last    = is_last;
  end

endmodule

@@ sv/sft_queue.sv @@
// Two-entry queue between the front end and the back end.
module sft_queue import sft_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  q_full,
  output logic  q_empty
);

  localparam int LVL_W = $clog2(Q_DEPTH + 1);

  item_t              slots [Q_DEPTH];
  logic [QP_W-1:0]    wr_ptr;
  logic [QP_W-1:0]    rd_ptr;
  logic [LVL_W-1:0]   level;
  logic               do_wr;
  logic               do_rd;

  assign q_full  = (level == LVL_W'(Q_DEPTH));
  assign q_empty = (level == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) level <= level + 1'b1;
      else if (do_rd && !do_wr) level <= level - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_item;
  end

endmodule

@@ sv/sft_back.sv @@
// Back end: entry store, column tallies, prefix sum, stable scatter and result output.
module sft_back import sft_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  item_t                   q_item,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic [COL_W-1:0]        out_row,
  output logic [ROW_W-1:0]        out_column,
  output logic signed [VAL_W-1:0] out_value,
  output logic [CNT_W-1:0]        entry_count,
  output logic                    out_last
);

  localparam int CW          = $clog2(MAX_ENTRIES + 1);
  localparam int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int TALLY_DEPTH = (MAX_COLUMNS < COL_SPAN) ? MAX_COLUMNS : COL_SPAN;
  localparam int TW          = (TALLY_DEPTH > 1) ? $clog2(TALLY_DEPTH) : 1;

  back_state_t state, state_next;

  // Memories
  logic [CW-1:0] tally_mem [TALLY_DEPTH];
  logic          tally_valid [TALLY_DEPTH];
  entry_t        store_mem [MAX_ENTRIES];
  entry_t        sort_mem  [MAX_ENTRIES];

  // Registers
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [TW-1:0] col_ptr;
  logic [CW-1:0] sum;
  entry_t        held;
  logic          held_last;
  logic [CW-1:0] tally_rd;
  logic          tally_rd_ok;
  entry_t        store_rd;
  entry_t        sort_rd;
  logic          out_valid;

  // Control from the sequencer
  logic          take_item;
  logic          load_wr;
  logic          pre_wr;
  logic          col_wrap;
  logic          sc_wr;
  logic          idx_end;
  logic          out_load;
  logic          done;
  logic [TW-1:0] tally_raddr;
  logic [TW-1:0] tally_waddr;
  logic [CW-1:0] tally_wdata;
  logic          tally_we;
  logic [CW-1:0] tval;
  logic          room;

  assign tval     = tally_rd_ok ? tally_rd : '0;
  assign room     = (count < CW'(MAX_ENTRIES));
  assign idx_end  = ((idx + 1'b1) == count);
  assign col_wrap = (col_ptr == TW'(TALLY_DEPTH - 1));
  assign empty    = !out_valid;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  // Next state and control
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    take_item   = 1'b0;
    load_wr     = 1'b0;
    pre_wr      = 1'b0;
    sc_wr       = 1'b0;
    out_load    = 1'b0;
    done        = 1'b0;
    tally_raddr = q_item.ent.col[TW-1:0];
    unique case (state)
      S_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.keep && room) begin
            take_item  = 1'b1;
            state_next = S_LOAD_WR;
          end else if (q_item.last) begin
            state_next = (count == '0) ? S_DONE : S_PRE_RD;
          end
        end
      end
      S_LOAD_WR: begin
        load_wr    = 1'b1;
        state_next = held_last ? S_PRE_RD : S_LOAD;
      end
      S_PRE_RD: begin
        tally_raddr = col_ptr;
        state_next  = S_PRE_WR;
      end
      S_PRE_WR: begin
        pre_wr     = 1'b1;
        state_next = col_wrap ? S_SC_RD : S_PRE_RD;
      end
      S_SC_RD: begin
        state_next = S_SC_COL;
      end
      S_SC_COL: begin
        tally_raddr = store_rd.col[TW-1:0];
        state_next  = S_SC_WR;
      end
      S_SC_WR: begin
        sc_wr      = 1'b1;
        state_next = idx_end ? S_EM_RD : S_SC_RD;
      end
      S_EM_RD: begin
        state_next = S_EM_WR;
      end
      S_EM_WR: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = idx_end ? S_DONE : S_EM_RD;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Tally write port
  always_comb begin
    tally_we    = load_wr || pre_wr || sc_wr;
    tally_waddr = held.col[TW-1:0];
    tally_wdata = tval + 1'b1;
    if (pre_wr) begin
      tally_waddr = col_ptr;
      tally_wdata = sum;
    end else if (sc_wr) begin
      tally_waddr = store_rd.col[TW-1:0];
    end
  end

  // Tally memory: counts while loading, start offsets after the prefix sum
  always_ff @(posedge clk) begin
    if (tally_we) tally_mem[tally_waddr] <= tally_wdata;
    tally_rd <= tally_mem[tally_raddr];
  end

  // Tally valid bits; an entry not written this matrix reads as zero
  always_ff @(posedge clk) begin
    if (rst || done) begin
      for (int i = 0; i < TALLY_DEPTH; i++) tally_valid[i] <= 1'b0;
    end else if (tally_we) begin
      tally_valid[tally_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    tally_rd_ok <= tally_valid[tally_raddr];
  end

  // Entry store and sorted copy
  always_ff @(posedge clk) begin
    if (load_wr) store_mem[count[AW-1:0]] <= held;
    if (sc_wr)   sort_mem[tval[AW-1:0]]   <= store_rd;
    store_rd <= store_mem[idx[AW-1:0]];
    sort_rd  <= sort_mem[idx[AW-1:0]];
  end

  // Latched item waiting for its tally update
  always_ff @(posedge clk) begin
    if (take_item) begin
      held      <= q_item.ent;
      held_last <= q_item.last;
    end
  end

  // Counters and running sum
  always_ff @(posedge clk) begin
    if (rst || done) begin
      count   <= '0;
      idx     <= '0;
      col_ptr <= '0;
      sum     <= '0;
    end else begin
      if (load_wr) count <= count + 1'b1;
      if (pre_wr) begin
        sum     <= sum + tval;
        col_ptr <= col_wrap ? '0 : col_ptr + 1'b1;
      end
      if (sc_wr || out_load) idx <= idx_end ? '0 : idx + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row     <= sort_rd.col;
      out_column  <= sort_rd.row;
      out_value   <= sort_rd.val;
      entry_count <= CNT_W'(count);
      out_last    <= idx_end;
    end
  end

endmodule

@@ sv/sparse_fast_transpose.sv @@
// Sparse matrix fast transpose: stores row/column/value triplets, counts entries per
// column, and when the item marked last arrives emits the transposed triplets in
// column-major order, keeping arrival order within a column. Entries with a column at
// or above the configured column count or MAX_COLUMNS, or arriving once MAX_ENTRIES
// are stored, are dropped; a dropped item marked last still ends the matrix. Each kept
// entry takes a tally read, then a tally and store write in the back end; a two-entry
// queue lets the input side run ahead. After the last item the back end runs a prefix
// sum over min(MAX_COLUMNS, 64) columns (tally read, then offset write), a scatter of
// each stored entry (store read, tally read, sorted write) and an output pass; the
// tally memory has a single registered read port. The next matrix is taken only after
// the last result has been loaded into the output register.
module sparse_fast_transpose import sft_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    push,
  output logic                    full,
  input  logic [ROW_W-1:0]        row_index,
  input  logic [COL_W-1:0]        column_index,
  input  logic signed [VAL_W-1:0] entry_value,
  input  logic                    is_last,
  output logic                    empty,
  input  logic                    pop,
  output logic [COL_W-1:0]        out_row,
  output logic [ROW_W-1:0]        out_column,
  output logic signed [VAL_W-1:0] out_value,
  output logic [CNT_W-1:0]        entry_count,
  output logic                    out_last
);

  item_t f_item;
  item_t q_item;
  logic  f_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  // Classify and queue incoming transfers
  sft_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push),
    .row_index    (row_index),
    .column_index (column_index),
    .entry_value  (entry_value),
    .is_last      (is_last),
    .q_full       (q_full),
    .full         (full),
    .q_push       (f_push),
    .q_item       (f_item)
  );

  sft_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_item (f_item),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Store, sort and emit
  sft_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_item),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_row     (out_row),
    .out_column  (out_column),
    .out_value   (out_value),
    .entry_count (entry_count),
    .out_last    (out_last)
  );

endmodule

@@ sv/sft_checker.sv @@
// Port-level checks for the sparse fast transpose block, bound to the top level.
module sft_checker import sft_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    empty,
  input logic                    pop,
  input logic [COL_W-1:0]        out_row,
  input logic [ROW_W-1:0]        out_column,
  input logic signed [VAL_W-1:0] out_value,
  input logic [CNT_W-1:0]        entry_count,
  input logic                    out_last
);

  logic             mid;
  logic [COL_W-1:0] prev_row;
  logic [CNT_W-1:0] prev_cnt;
  logic             xfer;

  assign xfer = pop && !empty;

  // Track the previous result transfer within a matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (xfer) begin
      mid <= !out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      prev_row <= out_row;
      prev_cnt <= entry_count;
    end
  end

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // A waiting result holds until transferred
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_row) && $stable(out_column) &&
                          $stable(out_value) && $stable(out_last)))
    else $error("waiting result changed");

  // Results come out in column-major order
  a_order: assert property (@(posedge clk) disable iff (rst)
    (xfer && mid) |-> (out_row >= prev_row))
    else $error("transposed rows out of order");

  // Entry count is the same on every result of one matrix
  a_count: assert property (@(posedge clk) disable iff (rst)
    (xfer && mid) |-> (entry_count == prev_cnt))
    else $error("entry count changed within a matrix");

endmodule

bind sparse_fast_transpose sft_checker u_sft_checker (.*);
